/* hw/rtl/lru_object_cache_macros.svh */
// Assertion macros shared by the lru_object_cache RTL.
`ifndef LRU_OBJECT_CACHE_MACROS_SVH
`define LRU_OBJECT_CACHE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LRUOC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_object_cache: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define LRUOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_object_cache: next-cycle check failed");

`endif

/* hw/rtl/lruoc_pkg.sv */
// Shared types and constants of the LRU object cache.
package lruoc_pkg;

  localparam int KEY_W  = 64;
  localparam int DATA_W = 64;
  localparam int SLOT_W = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_AGE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_zero;
  } age_cmd_t;

endpackage

/* hw/rtl/lruoc_kv_ram.sv */
// Key and value word memory, one write port, one registered read port.
module lruoc_kv_ram #(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = 3
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic [lruoc_pkg::KEY_W-1:0]  wr_key,
  input  logic [lruoc_pkg::DATA_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [lruoc_pkg::KEY_W-1:0]  rd_key,
  output logic [lruoc_pkg::DATA_W-1:0] rd_data
);

  logic [lruoc_pkg::KEY_W+lruoc_pkg::DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_data};
    end
    if (rd_en) begin
      {rd_key, rd_data} <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/lruoc_age_ram.sv */
// Age memory with read-modify-write: clears or saturating-increments the last word read.
module lruoc_age_ram #(
  parameter int ENTRIES  = 8,
  parameter int IDX_W    = 3,
  parameter int AGE_BITS = 16
) (
  input  logic                 clk,
  input  lruoc_pkg::age_cmd_t  cmd,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  output logic [AGE_BITS-1:0]  rd_age
);

  logic [AGE_BITS-1:0] mem [ENTRIES];
  logic [AGE_BITS-1:0] wr_age;

  // wr_addr is the address read in the previous cycle, so rd_age is its old value
  always_comb begin
    if (cmd.wr_zero) begin
      wr_age = '0;
    end else if (rd_age == {AGE_BITS{1'b1}}) begin
      wr_age = rd_age;
    end else begin
      wr_age = rd_age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_age;
    end
    if (cmd.rd_en) begin
      rd_age <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/lru_object_cache.sv */
// Top level of the fully associative LRU object cache.
//
// Fully associative cache of ENTRIES key/value entries with LRU replacement by
// per-entry age counters. One transaction at a time: op 0 looks up key, op 1
// inserts key/data_in (lowest empty entry, else the first oldest; no dedup).
// Keys, values and ages live in single-read-port memories, so each request
// makes a scan pass over all entries, one per cycle, then (on a hit or insert)
// an age pass of the same length; a lookup miss skips the age pass. The result
// sits in an output register, so the next request is taken while it waits.
// No clearing pass: valid bits reset at once.
`include "lru_object_cache_macros.svh"

module lru_object_cache #(
  parameter int ENTRIES  = 8,
  parameter int AGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [lruoc_pkg::KEY_W-1:0]  key,
  input  logic [lruoc_pkg::DATA_W-1:0] data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [lruoc_pkg::DATA_W-1:0] data_out,
  output logic [lruoc_pkg::SLOT_W-1:0] slot
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  lruoc_pkg::state_t state, state_next;

  logic [ENTRIES-1:0] valid;

  logic                         req_op;
  logic [lruoc_pkg::KEY_W-1:0]  req_key;
  logic [lruoc_pkg::DATA_W-1:0] req_data;

  logic [IDX_W-1:0] idx;
  logic             issue_done;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             rd_en;
  logic             last_pend;

  logic                         found;
  logic [IDX_W-1:0]             hit_idx;
  logic [lruoc_pkg::DATA_W-1:0] hit_data;
  logic                         empty_found;
  logic [IDX_W-1:0]             empty_idx;
  logic                         have_best;
  logic [IDX_W-1:0]             best_idx;
  logic [AGE_BITS-1:0]          best_age;
  logic [IDX_W-1:0]             touch_idx;
  logic [IDX_W-1:0]             victim;

  logic                         kv_we;
  logic [lruoc_pkg::KEY_W-1:0]  kv_rd_key;
  logic [lruoc_pkg::DATA_W-1:0] kv_rd_data;
  lruoc_pkg::age_cmd_t          age_cmd;
  logic [AGE_BITS-1:0]          age_rd;
  logic                         resp_load;

  lruoc_kv_ram #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_kv_ram (
    .clk     (clk),
    .wr_en   (kv_we),
    .wr_addr (victim),
    .wr_key  (req_key),
    .wr_data (req_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_key  (kv_rd_key),
    .rd_data (kv_rd_data)
  );

  lruoc_age_ram #(
    .ENTRIES  (ENTRIES),
    .IDX_W    (IDX_W),
    .AGE_BITS (AGE_BITS)
  ) u_age_ram (
    .clk     (clk),
    .cmd     (age_cmd),
    .rd_addr (idx),
    .wr_addr (pend_idx),
    .rd_age  (age_rd)
  );

  assign last_pend = pend && (pend_idx == LAST_IDX);
  assign victim    = empty_found ? empty_idx : best_idx;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lruoc_pkg::ST_IDLE: begin
        if (in_valid) state_next = lruoc_pkg::ST_SCAN;
      end
      lruoc_pkg::ST_SCAN: begin
        if (last_pend) state_next = lruoc_pkg::ST_DECIDE;
      end
      lruoc_pkg::ST_DECIDE: begin
        if (req_op == lruoc_pkg::OP_LOOKUP && !found) begin
          state_next = lruoc_pkg::ST_RESP;
        end else begin
          state_next = lruoc_pkg::ST_AGE;
        end
      end
      lruoc_pkg::ST_AGE: begin
        if (last_pend) state_next = lruoc_pkg::ST_RESP;
      end
      lruoc_pkg::ST_RESP: begin
        if (!out_valid || out_ready) state_next = lruoc_pkg::ST_IDLE;
      end
      default: state_next = lruoc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready        = 1'b0;
    rd_en           = 1'b0;
    kv_we           = 1'b0;
    resp_load       = 1'b0;
    age_cmd.rd_en   = 1'b0;
    age_cmd.wr_en   = 1'b0;
    age_cmd.wr_zero = (pend_idx == touch_idx);
    case (state)
      lruoc_pkg::ST_IDLE:   in_ready = 1'b1;
      lruoc_pkg::ST_SCAN: begin
        rd_en         = !issue_done;
        age_cmd.rd_en = !issue_done;
      end
      lruoc_pkg::ST_DECIDE: kv_we = (req_op == lruoc_pkg::OP_INSERT);
      lruoc_pkg::ST_AGE: begin
        age_cmd.rd_en = !issue_done;
        // empty entries keep their age
        age_cmd.wr_en = pend && valid[pend_idx];
      end
      lruoc_pkg::ST_RESP:   resp_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lruoc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // address sequencer shared by both passes
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
    end else begin
      pend <= rd_en || age_cmd.rd_en;
      if (state == lruoc_pkg::ST_IDLE || state == lruoc_pkg::ST_DECIDE) begin
        idx        <= '0;
        issue_done <= 1'b0;
      end else if (rd_en || age_cmd.rd_en) begin
        if (idx == LAST_IDX) begin
          issue_done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
    pend_idx <= idx;
  end

  // request capture and scan results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op      <= op;
      req_key     <= key;
      req_data    <= data_in;
      found       <= 1'b0;
      empty_found <= 1'b0;
      have_best   <= 1'b0;
    end
    if (state == lruoc_pkg::ST_SCAN && pend) begin
      if (!found && valid[pend_idx] && kv_rd_key == req_key) begin
        found    <= 1'b1;
        hit_idx  <= pend_idx;
        hit_data <= kv_rd_data;
      end
      if (!empty_found && !valid[pend_idx]) begin
        empty_found <= 1'b1;
        empty_idx   <= pend_idx;
      end
      // strict compare keeps the first entry among equal oldest
      if (valid[pend_idx] && (!have_best || age_rd > best_age)) begin
        have_best <= 1'b1;
        best_idx  <= pend_idx;
        best_age  <= age_rd;
      end
    end
    if (state == lruoc_pkg::ST_DECIDE) begin
      touch_idx <= (req_op == lruoc_pkg::OP_LOOKUP) ? hit_idx : victim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (kv_we) begin
      valid[victim] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (resp_load) begin
      hit      <= (req_op == lruoc_pkg::OP_LOOKUP) && found;
      data_out <= ((req_op == lruoc_pkg::OP_LOOKUP) && found) ? hit_data : '0;
      slot     <= ((req_op == lruoc_pkg::OP_INSERT) || found)
                  ? lruoc_pkg::SLOT_W'(touch_idx) : '0;
    end
  end

  `LRUOC_ASSERT_NOW(a_touch_valid, clk, rst, state == lruoc_pkg::ST_AGE, valid[touch_idx])
  `LRUOC_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `LRUOC_ASSERT_NEXT(a_resp_holds, clk, rst,
    state == lruoc_pkg::ST_RESP && out_valid && !out_ready, state == lruoc_pkg::ST_RESP)
  `LRUOC_ASSERT_NOW(a_write_on_insert, clk, rst, kv_we, req_op == lruoc_pkg::OP_INSERT)

endmodule
